/* rtl/ufd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ufd_pkg
// Shared types and constants for the unmatched free detector.
// ----------------------------------------------------------------------------
package ufd_pkg;

    localparam int ADDR_W              = 64;
    localparam int COUNT_W             = 32;
    localparam int LIVE_W              = 9;
    localparam int DEFAULT_TABLE_DEPTH = 256;

    localparam int IN_TDATA_W  = 128;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;

    localparam logic [1:0] OP_MALLOC  = 2'd0;
    localparam logic [1:0] OP_CALLOC  = 2'd1;
    localparam logic [1:0] OP_REALLOC = 2'd2;
    localparam logic [1:0] OP_FREE    = 2'd3;

    localparam logic [1:0] KIND_NOP    = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    // event word travelling down the cell chain
    typedef struct packed {
        logic              valid;
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic              done;
    } ufd_word_t;

endpackage
`default_nettype wire

/* rtl/unmatched_free_detector_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// unmatched_free_detector_core
// Tracks live allocator addresses and flags frees that match none.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one allocator event per word (operation and valid flag in
//   tuser, addresses in tdata). m_axis returns one result word per event, in
//   order: unmatched / dropped flags in tuser, running miss count and live
//   address count in tdata.
//   Each event walks a chain of TABLE_DEPTH registered slot cells, then the
//   tail register; the first free cell takes an insert, the first used cell
//   holding the address takes a free. The result leaves the tail register on
//   m_axis; events following each other ride the chain one cell apart, so
//   throughput is one word per cycle while m_axis is not stalled.
//   Reset empties the table and clears both counters; no clearing pass.
//   While a result waits on m_axis with m_axis_tready low, the whole chain
//   holds and s_axis_tready is low.
// ----------------------------------------------------------------------------
module unmatched_free_detector_core
    import ufd_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // block_address, old_pointer
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,  // operation, entry_valid
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // unmatched_total, live_count, pad
    output logic [OUT_TUSER_W-1:0]      m_axis_tuser   // unmatched, table_full_drop
);

    logic              advance;
    logic [1:0]        operation;
    logic              entry_valid;
    logic [ADDR_W-1:0] block_address;
    logic [ADDR_W-1:0] old_pointer;
    ufd_word_t         chain [0:TABLE_DEPTH];
    ufd_word_t         entry_word;
    logic              unmatched;
    logic              table_full_drop;
    logic [COUNT_W-1:0] unmatched_total;
    logic [LIVE_W-1:0]  live_count;

    assign operation     = s_axis_tuser[1:0];
    assign entry_valid   = s_axis_tuser[2];
    assign block_address = s_axis_tdata[ADDR_W-1:0];
    assign old_pointer   = s_axis_tdata[2*ADDR_W-1:ADDR_W];

    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    always_comb
    begin
        entry_word       = '0;
        entry_word.valid = s_axis_tvalid;
        entry_word.kind  = KIND_NOP;
        entry_word.addr  = block_address;
        if (entry_valid && ((operation == OP_MALLOC) || (operation == OP_CALLOC)))
        begin
            entry_word.kind = KIND_INSERT;
        end
        else if (operation == OP_REALLOC)
        begin
            entry_word.kind = KIND_INSERT;
            entry_word.addr = old_pointer;
        end
        else if (entry_valid && (operation == OP_FREE))
        begin
            entry_word.kind = KIND_REMOVE;
        end
    end

    assign chain[0] = entry_word;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        ufd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .word_in  (chain[i]),
            .word_out (chain[i+1])
        );
    end

    ufd_tail #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_tail (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .word_in         (chain[TABLE_DEPTH]),
        .out_valid       (m_axis_tvalid),
        .unmatched       (unmatched),
        .table_full_drop (table_full_drop),
        .unmatched_total (unmatched_total),
        .live_count      (live_count)
    );

    assign m_axis_tuser = {table_full_drop, unmatched};
    assign m_axis_tdata = {{(OUT_TDATA_W-COUNT_W-LIVE_W){1'b0}}, live_count, unmatched_total};

endmodule
`default_nettype wire

/* rtl/ufd_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ufd_cell
// One table slot. Claims a passing insert if free, or a passing remove on an
// address hit, then hands the word to the next cell.
// ----------------------------------------------------------------------------
module ufd_cell
    import ufd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      advance,
    input  wire ufd_word_t word_in,
    output ufd_word_t      word_out
);

    logic              used_reg;
    logic              used_next;
    logic [ADDR_W-1:0] addr_reg;
    ufd_word_t         word_reg;
    ufd_word_t         word_next;
    logic              claim_ins;
    logic              claim_rem;

    assign claim_ins = word_in.valid && !word_in.done && (word_in.kind == KIND_INSERT)
                       && !used_reg;
    assign claim_rem = word_in.valid && !word_in.done && (word_in.kind == KIND_REMOVE)
                       && used_reg && (addr_reg == word_in.addr);

    always_comb
    begin
        used_next = used_reg;
        word_next = word_in;
        if (claim_ins)
        begin
            used_next      = 1'b1;
            word_next.done = 1'b1;
        end
        else if (claim_rem)
        begin
            used_next      = 1'b0;
            word_next.done = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            word_reg <= '0;
        end
        else if (advance)
        begin
            used_reg <= used_next;
            word_reg <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && claim_ins)
        begin
            addr_reg <= word_in.addr;
        end
    end

    assign word_out = word_reg;

endmodule
`default_nettype wire

/* rtl/ufd_tail.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ufd_tail
// End of the chain: flags unclaimed words, keeps the miss and live counts
// in event order, and holds the output word.
// ----------------------------------------------------------------------------
module ufd_tail
    import ufd_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire ufd_word_t  word_in,
    output logic            out_valid,
    output logic            unmatched,
    output logic            table_full_drop,
    output logic [COUNT_W-1:0] unmatched_total,
    output logic [LIVE_W-1:0]  live_count
);

    localparam int OCC_W = $clog2(TABLE_DEPTH + 1);

    logic               out_valid_reg;
    logic               miss_flag_reg;
    logic               drop_flag_reg;
    logic [COUNT_W-1:0] miss_reg;
    logic [COUNT_W-1:0] miss_next;
    logic [OCC_W-1:0]   occ_reg;
    logic [OCC_W-1:0]   occ_next;
    logic               miss;
    logic               drop;
    logic [OCC_W+LIVE_W-1:0] live_ext;

    assign miss = word_in.valid && (word_in.kind == KIND_REMOVE) && !word_in.done;
    assign drop = word_in.valid && (word_in.kind == KIND_INSERT) && !word_in.done;

    always_comb
    begin
        miss_next = miss_reg;
        occ_next  = occ_reg;
        if (miss && (miss_reg != {COUNT_W{1'b1}}))
        begin
            miss_next = miss_reg + COUNT_W'(1);
        end
        if (word_in.valid && word_in.done)
        begin
            case (word_in.kind)
                KIND_INSERT: occ_next = occ_reg + OCC_W'(1);
                KIND_REMOVE: occ_next = occ_reg - OCC_W'(1);
                default:     occ_next = occ_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            miss_flag_reg <= 1'b0;
            drop_flag_reg <= 1'b0;
            miss_reg      <= '0;
            occ_reg       <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= word_in.valid;
            if (word_in.valid)
            begin
                miss_flag_reg <= miss;
                drop_flag_reg <= drop;
                miss_reg      <= miss_next;
                occ_reg       <= occ_next;
            end
        end
    end

    assign live_ext        = {{LIVE_W{1'b0}}, occ_reg};
    assign out_valid       = out_valid_reg;
    assign unmatched       = miss_flag_reg;
    assign table_full_drop = drop_flag_reg;
    assign unmatched_total = miss_reg;
    assign live_count      = live_ext[LIVE_W-1:0];

`ifndef ASSERT_OFF
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(miss_flag_reg && drop_flag_reg))
        else $error("miss and drop flagged on one word");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(TABLE_DEPTH))
        else $error("occupancy above table depth");

    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && drop_flag_reg) |-> (occ_reg == OCC_W'(TABLE_DEPTH)))
        else $error("insert dropped while table not full");

    a_miss_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (miss_reg >= $past(miss_reg)))
        else $error("miss counter decreased");
`endif

endmodule
`default_nettype wire

/* verif/unmatched_free_detector_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unmatched_free_detector_checker
// Watches both stream ports of the detector. Each accepted event word is
// run through a local copy of the live-address table to predict its result.
// Each result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module unmatched_free_detector_checker
    import ufd_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // block_address, old_pointer
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,  // operation, entry_valid
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,  // unmatched_total, live_count, pad
    input  wire logic [OUT_TUSER_W-1:0] m_axis_tuser,  // unmatched, table_full_drop
    output int                          mismatches,
    output int                          outstanding,
    output int                          events_seen,
    output int                          results_checked,
    output int                          misses_seen,
    output int                          drops_seen,
    output int                          peak_live
);

    typedef struct packed {
        logic               unmatched;
        logic               table_full_drop;
        logic [COUNT_W-1:0] unmatched_total;
        logic [LIVE_W-1:0]  live_count;
    } free_result_t;

    logic [ADDR_W-1:0]  slot_addr [TABLE_DEPTH];
    bit                 slot_busy [TABLE_DEPTH];
    logic [COUNT_W-1:0] miss_count;
    int                 occupancy;
    free_result_t       pending_results [$];
    free_result_t       due;
    free_result_t       seen;

    function automatic free_result_t track_event(input logic [1:0] op, input logic vld,
                                                 input logic [ADDR_W-1:0] addr,
                                                 input logic [ADDR_W-1:0] old_ptr);
        free_result_t      r;
        logic              is_insert;
        logic [ADDR_W-1:0] key;
        bit                done;
        r         = '0;
        done      = 1'b0;
        is_insert = (op == OP_REALLOC) || (vld && (op == OP_MALLOC || op == OP_CALLOC));
        key       = (op == OP_REALLOC) ? old_ptr : addr;
        if (is_insert)
        begin
            for (int i = 0; i < TABLE_DEPTH && !done; i++)
            begin
                if (!slot_busy[i])
                begin
                    slot_busy[i] = 1'b1;
                    slot_addr[i] = key;
                    occupancy++;
                    done = 1'b1;
                end
            end
            r.table_full_drop = !done;
        end
        else if (vld && op == OP_FREE)
        begin
            // lowest used slot holding the address is released
            for (int i = 0; i < TABLE_DEPTH && !done; i++)
            begin
                if (slot_busy[i] && slot_addr[i] == addr)
                begin
                    slot_busy[i] = 1'b0;
                    occupancy--;
                    done = 1'b1;
                end
            end
            if (!done)
            begin
                r.unmatched = 1'b1;
                if (miss_count != '1)
                    miss_count++;
            end
        end
        r.unmatched_total = miss_count;
        r.live_count      = occupancy[LIVE_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (slot_busy[i])
                slot_busy[i] = 1'b0;
            miss_count = '0;
            occupancy  = 0;
            pending_results.delete();
            mismatches      = 0;
            outstanding     = 0;
            events_seen     = 0;
            results_checked = 0;
            misses_seen     = 0;
            drops_seen      = 0;
            peak_live       = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                pending_results.insert(pending_results.size(),
                                       track_event(s_axis_tuser[1:0], s_axis_tuser[2],
                                                   s_axis_tdata[ADDR_W-1:0],
                                                   s_axis_tdata[2*ADDR_W-1:ADDR_W]));
                events_seen++;
                if (occupancy > peak_live)
                    peak_live = occupancy;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.unmatched       = m_axis_tuser[0];
                seen.table_full_drop = m_axis_tuser[1];
                seen.unmatched_total = m_axis_tdata[COUNT_W-1:0];
                seen.live_count      = m_axis_tdata[COUNT_W+LIVE_W-1:COUNT_W];
                if (pending_results.size() == 0)
                begin
                    $error("result word with no event pending");
                    mismatches++;
                end
                else
                begin
                    due = pending_results.pop_front();
                    results_checked++;
                    if (seen.unmatched != due.unmatched)
                    begin
                        $error("unmatched: expected %0d, got %0d", due.unmatched, seen.unmatched);
                        mismatches++;
                    end
                    if (seen.table_full_drop != due.table_full_drop)
                    begin
                        $error("table_full_drop: expected %0d, got %0d",
                               due.table_full_drop, seen.table_full_drop);
                        mismatches++;
                    end
                    if (seen.unmatched_total != due.unmatched_total)
                    begin
                        $error("unmatched_total: expected %0d, got %0d",
                               due.unmatched_total, seen.unmatched_total);
                        mismatches++;
                    end
                    if (seen.live_count != due.live_count)
                    begin
                        $error("live_count: expected %0d, got %0d",
                               due.live_count, seen.live_count);
                        mismatches++;
                    end
                    if (due.unmatched)
                        misses_seen++;
                    if (due.table_full_drop)
                        drops_seen++;
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

/* verif/unmatched_free_detector_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unmatched_free_detector_core_tb
// Drives allocator event words into the detector: a directed opening,
// then random traffic that builds the table up, overfills it while the
// result side stalls, and drains part of it. Checking is in the checker.
// ----------------------------------------------------------------------------
module unmatched_free_detector_core_tb;
    import ufd_pkg::*;

    localparam int DEPTH       = DEFAULT_TABLE_DEPTH;
    localparam int HOLD_CYCLES = 1500;
    localparam int IDLE_LIMIT  = 20000;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // block_address, old_pointer
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // operation, entry_valid
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // unmatched_total, live_count, pad
    logic [OUT_TUSER_W-1:0] m_axis_tuser;        // unmatched, table_full_drop

    int mismatches, outstanding, events_seen, results_checked;
    int misses_seen, drops_seen, peak_live;

    bit  steady    = 1'b0;
    bit  hold_req  = 1'b0;
    bit  hold_done = 1'b0;
    int  overflow_sent = 0;
    int  idle_cycles   = 0;
    logic [ADDR_W-1:0] live_addrs [$];

    unmatched_free_detector_core #(.TABLE_DEPTH(DEPTH)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    unmatched_free_detector_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .events_seen     (events_seen),
        .results_checked (results_checked),
        .misses_seen     (misses_seen),
        .drops_seen      (drops_seen),
        .peak_live       (peak_live)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mixes fresh random addresses, a small clustered range and live ones
    function automatic logic [ADDR_W-1:0] pick_addr();
        case ($urandom_range(3))
            0, 1: return {$urandom, $urandom};
            2: return 64'h0000_7f00_0000_1000 + 64'($urandom_range(7)) * 64'h40;
            default:
                if (live_addrs.size() > 0)
                    return live_addrs[$urandom_range(live_addrs.size() - 1)];
                else
                    return {$urandom, $urandom};
        endcase
    endfunction

    // tracks the live set for stimulus shaping, then sends one word
    task automatic issue(input logic [1:0] op, input logic vld,
                         input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] old_ptr);
        bit gone;
        gone = 1'b0;
        if (op == OP_REALLOC || (vld && op != OP_FREE))
        begin
            if (live_addrs.size() < DEPTH)
                live_addrs.insert(live_addrs.size(), op == OP_REALLOC ? old_ptr : addr);
            else
                overflow_sent++;
        end
        else if (vld && op == OP_FREE)
        begin
            foreach (live_addrs[i])
            begin
                if (!gone && live_addrs[i] == addr)
                begin
                    live_addrs.delete(i);
                    gone = 1'b1;
                end
            end
        end
        while (!steady && $urandom_range(99) < 13)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {old_ptr, addr};
        s_axis_tuser  <= {vld, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_event(input int insert_pct);
        logic [1:0]        op;
        logic              vld;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] p;
        vld = ($urandom_range(9) != 0);
        a   = pick_addr();
        p   = pick_addr();
        if ($urandom_range(99) < insert_pct)
        begin
            case ($urandom_range(2))
                0:       op = OP_MALLOC;
                1:       op = OP_CALLOC;
                default: op = OP_REALLOC;
            endcase
        end
        else
        begin
            op = OP_FREE;
            if (live_addrs.size() > 0 && $urandom_range(99) < 75)
                a = live_addrs[$urandom_range(live_addrs.size() - 1)];
        end
        issue(op, vld, a, p);
    endtask

    // result side: random back-pressure plus one long hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            m_axis_tready <= steady || ($urandom_range(99) >= 13);
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed opening
        issue(OP_FREE,    1'b1, 64'h0,                     64'h0);   // miss on empty table
        issue(OP_MALLOC,  1'b1, 64'h0,                     64'h0);
        issue(OP_CALLOC,  1'b1, 64'hFFFF_FFFF_FFFF_FFFF,   64'hFFFF_FFFF_FFFF_FFFF);
        issue(OP_MALLOC,  1'b0, 64'h1234_5678_9ABC_DEF0,   64'h0);   // ignored
        issue(OP_CALLOC,  1'b0, 64'hAAAA_AAAA_AAAA_AAAA,   64'h5555_5555_5555_5555);
        issue(OP_REALLOC, 1'b0, 64'hDEAD_BEEF_0000_0001,   64'h5555_5555_5555_5555);
        issue(OP_REALLOC, 1'b1, 64'h0000_0000_0000_0002,   64'hAAAA_AAAA_AAAA_AAAA);
        issue(OP_FREE,    1'b1, 64'h5555_5555_5555_5555,   64'hFFFF_FFFF_FFFF_FFFF);
        issue(OP_FREE,    1'b1, 64'h5555_5555_5555_5555,   64'h0);   // now a miss
        issue(OP_FREE,    1'b0, 64'h0,                     64'h0);   // ignored
        issue(OP_FREE,    1'b0, 64'h1111_2222_3333_4444,   64'h0);   // ignored, no match anyway
        issue(OP_MALLOC,  1'b1, 64'h0000_7F00_0000_1000,   64'h0);   // duplicate pair
        issue(OP_CALLOC,  1'b1, 64'h0000_7F00_0000_1000,   64'h0);
        issue(OP_FREE,    1'b1, 64'h0000_7F00_0000_1000,   64'h0);
        issue(OP_MALLOC,  1'b1, 64'h0000_7F00_0000_1040,   64'h0);   // fills the freed slot
        issue(OP_FREE,    1'b1, 64'h0000_7F00_0000_1000,   64'h0);
        issue(OP_FREE,    1'b1, 64'h0000_7F00_0000_1000,   64'h0);   // third free misses
        issue(OP_FREE,    1'b1, 64'hFFFF_FFFF_FFFF_FFFF,   64'h0);
        issue(OP_FREE,    1'b1, 64'h0,                     64'h0);
        issue(OP_FREE,    1'b1, 64'hAAAA_AAAA_AAAA_AAAA,   64'h0);
        issue(OP_FREE,    1'b1, 64'h0000_7F00_0000_1040,   64'h0);

        // balanced traffic, with a stretch free of idling on both sides
        for (int n = 0; n < 90; n++)
        begin
            steady = (n >= 30 && n < 75);
            random_event(60);
        end
        steady = 1'b0;

        // overfill the table; the result side stalls long while we push
        while (overflow_sent < 24)
        begin
            if (!hold_req && live_addrs.size() > 100)
                hold_req = 1'b1;
            random_event(92);
        end

        // partial drain
        repeat (40) random_event(20);

        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DEPTH + 20) @(negedge clk);

        $display("Sent %0d event words, checked %0d results: %0d unmatched frees, %0d dropped",
                 events_seen, results_checked, misses_seen, drops_seen);
        $display("inserts, live count peaked at %0d, one result-side hold of %0d cycles.",
                 peak_live, HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
